/* sv/cramer_3x3_solver_unit_macros.svh */
// Assertion macros for the Cramer solver checker.
`ifndef CRAMER_3X3_SOLVER_UNIT_MACROS_SVH
`define CRAMER_3X3_SOLVER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CR_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CR_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* sv/cr3_pkg.sv */
// Package with widths, codes and command types for the Cramer solver.
package cr3_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OUT_WIDTH       = 32;
    localparam int SLOT_WIDTH      = 4;
    localparam int STATUS_WIDTH    = 2;
    localparam int NUM_COEF        = 9;
    localparam int NUM_SLOTS       = 12;

    localparam logic [STATUS_WIDTH-1:0] ST_UNIQUE       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_UNDETERMINED = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_INCONSISTENT = 2'd2;

    // Operations of the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_MUL1,
        OP_MUL2,
        OP_ACC,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] det_idx;   // 0 base, 1..3 substituted
        logic [2:0] term_idx;  // 0..5
        logic [1:0] quo_idx;   // 0..2
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic base_zero;
    } t_stat;
endpackage

/* sv/cr3_datapath.sv */
// Datapath of the Cramer solver: stores, shared multiplier, accumulators and divider.
module cr3_datapath import cr3_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [SLOT_WIDTH-1:0]        i_slot,
    input  logic signed [OUT_WIDTH-1:0]  i_value,
    output t_stat                        o_stat,
    output logic [STATUS_WIDTH-1:0]      o_status,
    output logic signed [OUT_WIDTH-1:0]  o_x,
    output logic signed [OUT_WIDTH-1:0]  o_y,
    output logic signed [OUT_WIDTH-1:0]  o_z
);
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int DW = 3 * VALUE_WIDTH + 3;
    localparam int NW = DW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int HW = (VALUE_WIDTH + 1) / 2;

    logic signed [VALUE_WIDTH-1:0] r_coef [NUM_COEF];
    logic signed [VALUE_WIDTH-1:0] r_rhs  [3];
    logic signed [PW-1:0]          r_prod;
    logic signed [DW-1:0]          r_term;
    logic signed [DW-1:0]          r_det  [4];
    logic [NW-1:0]                 r_num;
    logic [DW-1:0]                 r_den;
    logic [DW:0]                   r_rem;
    logic [NW-1:0]                 r_quo;
    logic                          r_neg;
    logic [CW-1:0]                 r_cnt;
    logic signed [OUT_WIDTH-1:0]   r_res [3];
    logic [STATUS_WIDTH-1:0]       r_status;
    logic signed [DW+2:0]          r_msum;
    logic [1:0]                    r_mph;

    logic signed [VALUE_WIDTH-1:0] w_a, w_b, w_c;
    logic signed [VALUE_WIDTH-1:0] w_m [3][3];
    logic [DW:0]                   w_trial;
    logic signed [DW-1:0]          w_num_s, w_den_s;
    logic [VALUE_WIDTH-1:0]        w_lim_pos;
    logic [VALUE_WIDTH-1:0]        w_res;
    logic                          w_big;
    logic                          w_neg_term;

    // Matrix entries with row k replaced by the right-hand sides.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (i_cmd.det_idx != 2'd0 && r == int'(i_cmd.det_idx) - 1) begin
                    w_m[r][c] = r_rhs[c];
                end else begin
                    w_m[r][c] = r_coef[r*3+c];
                end
            end
        end
        w_neg_term = 1'b0;
        unique case (i_cmd.term_idx)
            3'd0: begin w_a = w_m[0][0]; w_b = w_m[1][1]; w_c = w_m[2][2]; end
            3'd1: begin w_a = w_m[0][1]; w_b = w_m[1][2]; w_c = w_m[2][0]; end
            3'd2: begin w_a = w_m[1][0]; w_b = w_m[2][1]; w_c = w_m[0][2]; end
            3'd3: begin
                w_a = w_m[0][2]; w_b = w_m[1][1]; w_c = w_m[2][0]; w_neg_term = 1'b1;
            end
            3'd4: begin
                w_a = w_m[0][1]; w_b = w_m[1][0]; w_c = w_m[2][2]; w_neg_term = 1'b1;
            end
            default: begin
                w_a = w_m[0][0]; w_b = w_m[1][2]; w_c = w_m[2][1]; w_neg_term = 1'b1;
            end
        endcase
    end

    // The second product (prod * c) is split into halves of c to keep multipliers narrow.
    logic signed [HW:0]              w_c_part;
    logic signed [PW+HW+1:0]         w_pp;
    always_comb begin
        if (r_mph == 2'd0) begin
            w_c_part = $signed({1'b0, w_c[HW-1:0]});
        end else begin
            w_c_part = (HW+1)'(w_c >>> HW);
        end
        w_pp = r_prod * w_c_part;
    end

    assign w_num_s  = (i_cmd.quo_idx == 2'd0) ? r_det[1] :
                      (i_cmd.quo_idx == 2'd1) ? r_det[2] : r_det[3];
    assign w_den_s  = r_det[0];
    assign w_trial  = {r_rem[DW-1:0], r_num[NW-1]} - {1'b0, r_den};
    assign w_lim_pos = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    assign w_big    = (r_quo >> (VALUE_WIDTH - 1)) != '0;

    always_comb begin
        if (r_neg) begin
            if (w_big && r_quo != (NW'(1) << (VALUE_WIDTH - 1))) begin
                w_res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            end else begin
                w_res = VALUE_WIDTH'(-r_quo);
            end
        end else begin
            w_res = w_big ? w_lim_pos : r_quo[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) r_coef[i] <= '0;
            for (int i = 0; i < 3; i++) r_rhs[i] <= '0;
            r_mph    <= '0;
            r_status <= ST_UNDETERMINED;
        end else begin
            unique case (i_cmd.op)
                OP_WRITE: begin
                    if (i_slot < SLOT_WIDTH'(NUM_COEF)) begin
                        r_coef[i_slot] <= VALUE_WIDTH'($unsigned(i_value));
                    end else if (i_slot < SLOT_WIDTH'(NUM_SLOTS)) begin
                        r_rhs[2'(i_slot - SLOT_WIDTH'(NUM_COEF))] <=
                            VALUE_WIDTH'($unsigned(i_value));
                    end
                    for (int i = 0; i < 4; i++) r_det[i] <= '0;
                end
                OP_MUL1: begin
                    r_prod <= PW'(w_a * w_b);
                    r_mph  <= 2'd0;
                end
                OP_MUL2: begin
                    if (r_mph == 2'd0) begin
                        r_msum <= (DW+3)'(w_pp);
                        r_mph  <= 2'd1;
                    end else begin
                        r_term <= DW'(r_msum + ((DW+3)'(w_pp) <<< HW));
                        r_mph  <= 2'd0;
                    end
                end
                OP_ACC: begin
                    if (w_neg_term) begin
                        r_det[i_cmd.det_idx] <= r_det[i_cmd.det_idx] - r_term;
                    end else begin
                        r_det[i_cmd.det_idx] <= r_det[i_cmd.det_idx] + r_term;
                    end
                end
                OP_DIV_START: begin
                    r_neg <= w_num_s[DW-1] ^ w_den_s[DW-1];
                    r_num <= NW'(w_num_s[DW-1] ? DW'(-w_num_s) : DW'(w_num_s)) << FRAC_BITS;
                    r_den <= w_den_s[DW-1] ? DW'(-w_den_s) : DW'(w_den_s);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CW'(NW);
                    if (r_det[0] == '0) begin
                        r_status <= (r_det[1] == '0 && r_det[2] == '0 && r_det[3] == '0)
                                    ? ST_UNDETERMINED : ST_INCONSISTENT;
                        for (int i = 0; i < 3; i++) r_res[i] <= '0;
                    end else begin
                        r_status <= ST_UNIQUE;
                    end
                end
                OP_DIV_STEP: begin
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (!w_trial[DW]) begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DW-1:0], r_num[NW-1]};
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                end
                OP_DIV_END: begin
                    r_res[i_cmd.quo_idx] <= OUT_WIDTH'($signed(w_res));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.div_done  = (r_cnt == '0);
    assign o_stat.base_zero = (r_det[0] == '0);
    assign o_status = r_status;
    assign o_x = r_res[0];
    assign o_y = r_res[1];
    assign o_z = r_res[2];
endmodule

/* sv/cr3_controller.sv */
// Sequencer of the Cramer solver: determinant terms, divisions and handshakes.
module cr3_controller import cr3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2A, S_MUL2B, S_ACC, S_DSTART, S_DSTEP, S_DEND
    } t_state;

    t_state     r_state;
    logic [1:0] r_det;
    logic [2:0] r_term;
    logic [1:0] r_quo;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.det_idx  = r_det;
        o_cmd.term_idx = r_term;
        o_cmd.quo_idx  = r_quo;
        unique case (r_state)
            S_IDLE:   o_cmd.op = (i_in_valid && o_in_ready) ? OP_WRITE : OP_NONE;
            S_MUL1:   o_cmd.op = OP_MUL1;
            S_MUL2A,
            S_MUL2B:  o_cmd.op = OP_MUL2;
            S_ACC:    o_cmd.op = OP_ACC;
            S_DSTART: o_cmd.op = OP_DIV_START;
            S_DSTEP:  o_cmd.op = i_stat.div_done ? OP_NONE : OP_DIV_STEP;
            default:  o_cmd.op = OP_DIV_END;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_det       <= '0;
            r_term      <= '0;
            r_quo       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_det   <= '0;
                        r_term  <= '0;
                        r_quo   <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1:  r_state <= S_MUL2A;
                S_MUL2A: r_state <= S_MUL2B;
                S_MUL2B: r_state <= S_ACC;
                S_ACC: begin
                    if (r_term != 3'd5) begin
                        r_term  <= r_term + 3'd1;
                        r_state <= S_MUL1;
                    end else if (r_det != 2'd3) begin
                        r_term  <= '0;
                        r_det   <= r_det + 2'd1;
                        r_state <= S_MUL1;
                    end else begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    if (i_stat.base_zero) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_DSTEP;
                    end
                end
                S_DSTEP: begin
                    if (i_stat.div_done) r_state <= S_DEND;
                end
                default: begin
                    if (r_quo != 2'd2) begin
                        r_quo   <= r_quo + 2'd1;
                        r_state <= S_DSTART;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

/* sv/cramer_3x3_solver_unit.sv */
// Top level of the 3x3 Cramer's rule solver.
// Channel | Direction | tdata fields (low to high)        | tuser
// s_axis  | in        | slot[3:0], value[35:4]            | none
// m_axis  | out       | x[31:0], y[63:32], z[95:64]       | status[1:0]
// A result is valid after the four determinants and, for a nonzero base determinant,
// the three divisions; the next input beat is taken once that result has been taken.
// Twenty-four determinant terms each pass the shared multiplier and an accumulator.
// Each quotient takes a load, 3*VALUE_WIDTH+3+FRAC_BITS restoring steps and a closing write.
// Reset clears both stores to zero; a result waits in its register until taken.
module cramer_3x3_solver_unit import cr3_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [39:0]             s_axis_tdata,   // slot[3:0], value[35:4]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [95:0]             m_axis_tdata,   // x_value, y_value, z_value
    output logic [STATUS_WIDTH-1:0] m_axis_tuser    // status
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic signed [OUT_WIDTH-1:0] w_x, w_y, w_z;
    logic [STATUS_WIDTH-1:0]     w_status;

    cr3_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cr3_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_slot   (s_axis_tdata[3:0]),
        .i_value  (s_axis_tdata[35:4]),
        .o_stat   (w_stat),
        .o_status (w_status),
        .o_x      (w_x),
        .o_y      (w_y),
        .o_z      (w_z)
    );

    assign m_axis_tdata = {w_z, w_y, w_x};
    assign m_axis_tuser = w_status;
endmodule

/* sv/cr3_checker.sv */
// Port checker for the Cramer solver, bound to the top level.
`include "cramer_3x3_solver_unit_macros.svh"
module cr3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    `CR_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3)
    `CR_ASSERT_IMP(a_zero_unless_unique, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != 2'd0, m_axis_tdata == '0)
    `CR_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
    `CR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind cramer_3x3_solver_unit cr3_checker u_cr3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/tb_cramer_3x3_solver_unit.sv */
// Self-checking testbench for the 3x3 Cramer's rule solver with an exact determinant predictor.
module tb_cramer_3x3_solver_unit;
    import cr3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 1825;

    typedef struct {
        logic [3:0]  slot;
        logic [31:0] value;
    } t_write;

    typedef struct {
        logic [STATUS_WIDTH-1:0] status;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_solution;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [STATUS_WIDTH-1:0] m_axis_tuser;

    t_write    write_queue[$];
    t_solution solution_queue[$];
    logic signed [31:0] coef_model[9];
    logic signed [31:0] rhs_model[3];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_sender = 1'b0;
    bit  failed = 1'b0;
    int  idle_cycles = 0;

    cramer_3x3_solver_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [127:0] det3(logic signed [127:0] m[3][3]);
        return m[0][0]*m[1][1]*m[2][2] + m[0][1]*m[1][2]*m[2][0] + m[1][0]*m[2][1]*m[0][2]
             - m[0][2]*m[1][1]*m[2][0] - m[0][1]*m[1][0]*m[2][2] - m[0][0]*m[1][2]*m[2][1];
    endfunction

    function automatic logic [31:0] saturated_quotient(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic signed [191:0] n;
        logic signed [191:0] q;
        n = num;
        n = n <<< FB;
        q = n / den;
        if (q > 192'sd2147483647) return 32'h7fffffff;
        if (q < -192'sd2147483648) return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic t_solution solve_after_write(t_write w);
        logic signed [127:0] m[3][3];
        logic signed [127:0] t[3][3];
        logic signed [127:0] base;
        logic signed [127:0] dk[3];
        t_solution s;
        if (w.slot < 9) coef_model[w.slot] = w.value;
        else if (w.slot < 12) rhs_model[w.slot - 9] = w.value;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) m[r][c] = coef_model[r*3 + c];
        base = det3(m);
        for (int k = 0; k < 3; k++) begin
            t = m;
            for (int c = 0; c < 3; c++) t[k][c] = rhs_model[c];
            dk[k] = det3(t);
        end
        s = '{ST_UNIQUE, 32'd0, 32'd0, 32'd0};
        if (base != 0) begin
            s.x = saturated_quotient(dk[0], base);
            s.y = saturated_quotient(dk[1], base);
            s.z = saturated_quotient(dk[2], base);
        end else if (dk[0] == 0 && dk[1] == 0 && dk[2] == 0) begin
            s.status = ST_UNDETERMINED;
        end else begin
            s.status = ST_INCONSISTENT;
        end
        return s;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            4: return 32'($signed($urandom_range(0, 64)) - 32) << FB;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                solution_queue = {solution_queue, solve_after_write(write_queue.pop_front())};
            end
            if ((!s_axis_tvalid || s_axis_tready) && !(s_axis_tvalid && s_axis_tready
                    && write_queue.size() == 0 && 0)) begin
                if (write_queue.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                        && !hold_sender && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'd0, write_queue[0].value, write_queue[0].slot};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_solution got;
        t_solution want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (solution_queue.size() == 0) begin
                $display("%0t: unexpected beat, actual %p", $time, got);
                failed = 1'b1;
            end else begin
                want = solution_queue.pop_front();
                if (got.status != want.status || got.x != want.x || got.y != want.y
                        || got.z != want.z) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || hold_sender)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_write(int slot, logic [31:0] value);
        t_write w;
        w.slot = 4'(slot);
        w.value = value;
        write_queue = {write_queue, w};
    endtask

    task automatic wait_drained();
        while (write_queue.size() != 0 || s_axis_tvalid || solution_queue.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int pct[4][2];
        pct[0][0] = 0;
        pct[0][1] = 0;
        pct[1][0] = 57;
        pct[1][1] = 0;
        pct[2][0] = 0;
        pct[2][1] = 57;
        pct[3][0] = 15;
        pct[3][1] = 15;
        for (int i = 0; i < 9; i++) coef_model[i] = 0;
        for (int i = 0; i < 3; i++) rhs_model[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: empty system, identity, out of range slots, extremes, saturation.
        add_write(11, 32'd5 << FB);
        add_write(0, 32'd1 << FB);
        add_write(4, 32'd1 << FB);
        add_write(8, 32'd1 << FB);
        add_write(9, 32'h7fffffff);
        add_write(10, 32'h80000000);
        add_write(12, 32'hffffffff);
        add_write(15, 32'h12345678);
        add_write(0, 32'd1);
        add_write(4, 32'h80000000);
        add_write(8, 32'h7fffffff);
        add_write(3, 32'h7fffffff);
        add_write(1, 32'hffffffff);
        add_write(4, 32'd0);
        add_write(8, 32'd0);
        add_write(5, 32'd2 << FB);
        add_write(2, 32'd3 << FB);
        add_write(6, 32'hffff0000);
        add_write(7, 32'd0);
        add_write(0, 32'd0);
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = pct[p][0];
            recv_stall_pct = pct[p][1];
            for (int i = 0; i < NUM_RANDOM / 4; i++)
                add_write($urandom_range(0, 99) < 5 ? $urandom_range(12, 15)
                                                    : $urandom_range(0, 11), random_value());
            if (p == 1) begin
                wait_drained();
                hold_sender = 1'b1;
                repeat (20) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        repeat (600) @(posedge i_clk);
        if (!failed && solution_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
